FILE: design/esss_pkg.sv
// ----------------------------------------------------------------------------
// esss_pkg
// Shared types, codes and helpers of the scanline edge stepper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package esss_pkg;

    localparam int COORD_W = 20;
    localparam int ROW_W   = 13;
    localparam int VAL_W   = 32;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_ATTR  = 3;
    localparam int SUM_W   = 60;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DU_DX = 3'd0,
        CFG_DU_DY = 3'd1,
        CFG_DV_DX = 3'd2,
        CFG_DV_DY = 3'd3,
        CFG_DW_DX = 3'd4,
        CFG_DW_DY = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic                        cmd;
        logic signed [COORD_W-1:0]   sx;
        logic signed [ROW_W-1:0]     first_row;
        logic signed [ROW_W-1:0]     stop_row;
        logic [7:0]                  ypre;
        logic signed [COORD_W:0]     dx;
        logic signed [COORD_W:0]     dy;
        logic                        flat;
        logic signed [VAL_W-1:0]     su;
        logic signed [VAL_W-1:0]     sv;
        logic signed [VAL_W-1:0]     sw;
    } cq_entry_t;

    typedef struct packed {
        logic signed [ROW_W-1:0]     row_first;
        logic signed [ROW_W-1:0]     row_stop;
        logic signed [VAL_W-1:0]     edge_x;
        logic signed [VAL_W-1:0]     tex_u;
        logic signed [VAL_W-1:0]     tex_v;
        logic signed [VAL_W-1:0]     inv_depth;
        logic                        degenerate;
    } result_t;

    typedef struct packed {
        logic                        start;
        logic signed [COORD_W:0]     dx;
        logic signed [COORD_W:0]     dy;
    } div_req_t;

    typedef struct packed {
        logic                        done;
        logic signed [VAL_W-1:0]     quot;
    } div_rsp_t;

    function automatic logic signed [SUM_W-1:0] sext32(input logic signed [VAL_W-1:0] x);
        return {{(SUM_W-VAL_W){x[VAL_W-1]}}, x};
    endfunction

    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [SUM_W-1:0] x);
        logic over;
        logic under;
        over  = !x[SUM_W-1] && (|x[SUM_W-2:VAL_W-1]);
        under = x[SUM_W-1] && !(&x[SUM_W-2:VAL_W-1]);
        if (over)
            return {1'b0, {(VAL_W-1){1'b1}}};
        else if (under)
            return {1'b1, {(VAL_W-1){1'b0}}};
        else
            return x[VAL_W-1:0];
    endfunction

endpackage

FILE: design/esss_fifo.sv
// ----------------------------------------------------------------------------
// esss_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module esss_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

endmodule

FILE: design/esss_front.sv
// ----------------------------------------------------------------------------
// esss_front
// Classify a request and set up its row bounds, y prestep and edge deltas.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module esss_front
    import esss_pkg::*;
(
    input  logic                       cmd,
    input  logic signed [COORD_W-1:0]  start_x,
    input  logic signed [COORD_W-1:0]  start_y,
    input  logic signed [COORD_W-1:0]  end_x,
    input  logic signed [COORD_W-1:0]  end_y,
    input  logic signed [VAL_W-1:0]    start_u,
    input  logic signed [VAL_W-1:0]    start_v,
    input  logic signed [VAL_W-1:0]    start_w,
    output cq_entry_t                  entry
);

    logic signed [COORD_W:0] sy_ext;
    logic signed [COORD_W:0] ey_ext;
    logic signed [COORD_W:0] sy_ceil;
    logic signed [COORD_W:0] ey_ceil;
    logic signed [COORD_W:0] ypre_full;

    assign sy_ext    = {start_y[COORD_W-1], start_y};
    assign ey_ext    = {end_y[COORD_W-1], end_y};
    assign sy_ceil   = sy_ext + (COORD_W+1)'(255);
    assign ey_ceil   = ey_ext + (COORD_W+1)'(255);
    assign ypre_full = {sy_ceil[COORD_W:8], 8'd0} - sy_ext;

    always_comb
    begin
        entry.cmd       = cmd;
        entry.sx        = start_x;
        entry.first_row = sy_ceil[COORD_W:8];
        entry.stop_row  = ey_ceil[COORD_W:8];
        entry.ypre      = ypre_full[7:0];
        entry.dx        = {end_x[COORD_W-1], end_x} - {start_x[COORD_W-1], start_x};
        entry.dy        = ey_ext - sy_ext;
        entry.flat      = (ey_ext == sy_ext);
        entry.su        = start_u;
        entry.sv        = start_v;
        entry.sw        = start_w;
    end

endmodule

FILE: design/esss_div.sv
// ----------------------------------------------------------------------------
// esss_div
// Restoring divider for the x slope, one quotient bit per cycle, saturated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module esss_div
    import esss_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int MAG_W = COORD_W;
    localparam int NUM_W = COORD_W + FRAC_BITS;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic             neg_reg, neg_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [MAG_W-1:0] rem_reg, rem_next;
    logic [MAG_W-1:0] dm_reg, dm_next;
    logic [NUM_W-1:0] num_reg, num_next;

    logic [COORD_W:0] dx_abs;
    logic [COORD_W:0] dy_abs;
    logic [MAG_W:0]   shifted;
    logic [MAG_W:0]   trial;
    logic [63:0]      q_ext;
    logic             q_big;
    logic [VAL_W-1:0] q_low;

    assign dx_abs  = req.dx[COORD_W] ? -req.dx : req.dx;
    assign dy_abs  = req.dy[COORD_W] ? -req.dy : req.dy;
    assign shifted = {rem_reg, num_reg[NUM_W-1]};
    assign trial   = shifted - {1'b0, dm_reg};
    assign q_ext   = 64'(num_reg);
    assign q_big   = |q_ext[63:VAL_W-1];
    assign q_low   = {1'b0, q_ext[VAL_W-2:0]};

    always_comb
    begin
        rsp.done = done_reg;
        if (neg_reg)
            rsp.quot = q_big ? {1'b1, {(VAL_W-1){1'b0}}} : VAL_W'(0) - q_low;
        else
            rsp.quot = q_big ? {1'b0, {(VAL_W-1){1'b1}}} : q_low;
    end

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dm_next   = dm_reg;
        num_next  = num_reg;
        if (req.start)
        begin
            run_next = 1'b1;
            neg_next = req.dx[COORD_W] ^ req.dy[COORD_W];
            cnt_next = CNT_W'(NUM_W);
            rem_next = '0;
            dm_next  = dy_abs[MAG_W-1:0];
            num_next = {dx_abs[MAG_W-1:0], {FRAC_BITS{1'b0}}};
        end
        else if (run_reg)
        begin
            rem_next = trial[MAG_W] ? shifted[MAG_W-1:0] : trial[MAG_W-1:0];
            num_next = {num_reg[NUM_W-2:0], !trial[MAG_W]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            neg_reg  <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            dm_reg   <= '0;
            num_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            neg_reg  <= neg_next;
            cnt_reg  <= cnt_next;
            rem_reg  <= rem_next;
            dm_reg   <= dm_next;
            num_reg  <= num_next;
        end
    end

endmodule

FILE: design/esss_back.sv
// ----------------------------------------------------------------------------
// esss_back
// Execute queued requests: row steps, and edge setup on a shared multiplier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module esss_back
    import esss_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    input  cq_entry_t             cq_rdata,
    input  logic                  cq_empty,
    output logic                  cq_pop,
    output div_req_t              div_req,
    input  div_rsp_t              div_rsp,
    output result_t               oq_wdata,
    output logic                  oq_push,
    input  logic                  oq_full
);

    localparam int MUL_W  = VAL_W + 1;
    localparam int PROD_W = 2 * MUL_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_ACC,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        PH_XPRE,
        PH_TA,
        PH_TB,
        PH_TC
    } phase_t;

    state_t                     state_reg, state_next;
    phase_t                     phase_reg, phase_next;
    logic [1:0]                 attr_reg, attr_next;

    logic signed [VAL_W-1:0]    gx_reg [NUM_ATTR];
    logic signed [VAL_W-1:0]    gx_next [NUM_ATTR];
    logic signed [VAL_W-1:0]    gy_reg [NUM_ATTR];
    logic signed [VAL_W-1:0]    gy_next [NUM_ATTR];
    logic signed [VAL_W-1:0]    st_reg [NUM_ATTR];
    logic signed [VAL_W-1:0]    st_next [NUM_ATTR];
    logic signed [VAL_W-1:0]    acc_reg [NUM_ATTR];
    logic signed [VAL_W-1:0]    acc_next [NUM_ATTR];
    logic signed [VAL_W-1:0]    step_reg [NUM_ATTR];
    logic signed [VAL_W-1:0]    step_next [NUM_ATTR];

    logic signed [COORD_W-1:0]  sx_reg, sx_next;
    logic [7:0]                 ypre_reg, ypre_next;
    logic signed [VAL_W-1:0]    slope_reg, slope_next;
    logic signed [VAL_W-1:0]    xpre_reg, xpre_next;
    logic signed [VAL_W-1:0]    x_acc_reg, x_acc_next;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    logic signed [SUM_W-1:0]    sum_reg, sum_next;
    logic signed [ROW_W-1:0]    first_reg, first_next;
    logic signed [ROW_W-1:0]    stop_reg, stop_next;
    logic                       flat_reg, flat_next;

    logic signed [MUL_W-1:0]    mul_a;
    logic signed [MUL_W-1:0]    mul_b;
    logic signed [MUL_W-1:0]    ypre_op;
    logic signed [VAL_W-1:0]    xpre_term;
    logic signed [SUM_W-1:0]    hi_term;
    logic signed [SUM_W-1:0]    lo_term;
    logic signed [SUM_W-1:0]    sx_scaled;

    assign ypre_op   = {{(MUL_W-8){1'b0}}, ypre_reg};
    assign prod_next = mul_a * mul_b;
    assign xpre_term = VAL_W'(prod_reg >>> 8);
    assign hi_term   = SUM_W'(prod_reg >>> FRAC_BITS);
    assign lo_term   = SUM_W'(prod_reg >>> 8);
    assign sx_scaled = {{(SUM_W-COORD_W){sx_reg[COORD_W-1]}}, sx_reg} <<< (FRAC_BITS - 8);

    always_comb
    begin
        unique case (phase_reg)
            PH_XPRE:
            begin
                mul_a = {slope_reg[VAL_W-1], slope_reg};
                mul_b = ypre_op;
            end
            PH_TA:
            begin
                mul_a = {gx_reg[attr_reg][VAL_W-1], gx_reg[attr_reg]};
                mul_b = {xpre_reg[VAL_W-1], xpre_reg};
            end
            PH_TB:
            begin
                mul_a = {gy_reg[attr_reg][VAL_W-1], gy_reg[attr_reg]};
                mul_b = ypre_op;
            end
            PH_TC:
            begin
                mul_a = {gx_reg[attr_reg][VAL_W-1], gx_reg[attr_reg]};
                mul_b = {slope_reg[VAL_W-1], slope_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        attr_next  = attr_reg;
        gx_next    = gx_reg;
        gy_next    = gy_reg;
        st_next    = st_reg;
        acc_next   = acc_reg;
        step_next  = step_reg;
        sx_next    = sx_reg;
        ypre_next  = ypre_reg;
        slope_next = slope_reg;
        xpre_next  = xpre_reg;
        x_acc_next = x_acc_reg;
        sum_next   = sum_reg;
        first_next = first_reg;
        stop_next  = stop_reg;
        flat_next  = flat_reg;
        cq_pop     = 1'b0;
        oq_push    = 1'b0;
        div_req.start = 1'b0;
        div_req.dx    = cq_rdata.dx;
        div_req.dy    = cq_rdata.dy;

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DU_DX: gx_next[0] = cfg_data;
                CFG_DU_DY: gy_next[0] = cfg_data;
                CFG_DV_DX: gx_next[1] = cfg_data;
                CFG_DV_DY: gy_next[1] = cfg_data;
                CFG_DW_DX: gx_next[2] = cfg_data;
                CFG_DW_DY: gy_next[2] = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!cq_empty)
                begin
                    if (cq_rdata.cmd == CMD_STEP)
                    begin
                        if (!oq_full)
                        begin
                            x_acc_next = sat32(sext32(x_acc_reg) + sext32(slope_reg));
                            for (int i = 0; i < NUM_ATTR; i++)
                            begin
                                acc_next[i] = sat32(sext32(acc_reg[i]) + sext32(step_reg[i]));
                            end
                            cq_pop  = 1'b1;
                            oq_push = 1'b1;
                        end
                    end
                    else
                    begin
                        cq_pop     = 1'b1;
                        sx_next    = cq_rdata.sx;
                        ypre_next  = cq_rdata.ypre;
                        st_next[0] = cq_rdata.su;
                        st_next[1] = cq_rdata.sv;
                        st_next[2] = cq_rdata.sw;
                        first_next = cq_rdata.first_row;
                        stop_next  = cq_rdata.stop_row;
                        flat_next  = cq_rdata.flat;
                        phase_next = PH_XPRE;
                        attr_next  = '0;
                        if (cq_rdata.flat)
                        begin
                            slope_next = '0;
                            state_next = ST_MUL;
                        end
                        else
                        begin
                            div_req.start = 1'b1;
                            state_next    = ST_DIV;
                        end
                    end
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    slope_next = div_rsp.quot;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                state_next = ST_MUL;
                unique case (phase_reg)
                    PH_XPRE:
                    begin
                        xpre_next  = xpre_term;
                        x_acc_next = sat32(sx_scaled + sext32(xpre_term));
                        phase_next = PH_TA;
                    end
                    PH_TA:
                    begin
                        sum_next   = sext32(st_reg[attr_reg]) + hi_term;
                        phase_next = PH_TB;
                    end
                    PH_TB:
                    begin
                        acc_next[attr_reg] = sat32(sum_reg + lo_term);
                        phase_next = PH_TC;
                    end
                    PH_TC:
                    begin
                        step_next[attr_reg] = sat32(sext32(gy_reg[attr_reg]) + hi_term);
                        phase_next = PH_TA;
                        if (attr_reg == 2'(NUM_ATTR - 1))
                            state_next = ST_DONE;
                        else
                            attr_next = attr_reg + 1'b1;
                    end
                    default: ;
                endcase
            end
            ST_DONE:
            begin
                if (!oq_full)
                begin
                    oq_push    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        oq_wdata.row_first  = first_next;
        oq_wdata.row_stop   = stop_next;
        oq_wdata.edge_x     = x_acc_next;
        oq_wdata.tex_u      = acc_next[0];
        oq_wdata.tex_v      = acc_next[1];
        oq_wdata.inv_depth  = acc_next[2];
        oq_wdata.degenerate = flat_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_XPRE;
            attr_reg  <= '0;
            for (int i = 0; i < NUM_ATTR; i++)
            begin
                gx_reg[i]   <= '0;
                gy_reg[i]   <= '0;
                st_reg[i]   <= '0;
                acc_reg[i]  <= '0;
                step_reg[i] <= '0;
            end
            sx_reg    <= '0;
            ypre_reg  <= '0;
            slope_reg <= '0;
            xpre_reg  <= '0;
            x_acc_reg <= '0;
            prod_reg  <= '0;
            sum_reg   <= '0;
            first_reg <= '0;
            stop_reg  <= '0;
            flat_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            attr_reg  <= attr_next;
            gx_reg    <= gx_next;
            gy_reg    <= gy_next;
            st_reg    <= st_next;
            acc_reg   <= acc_next;
            step_reg  <= step_next;
            sx_reg    <= sx_next;
            ypre_reg  <= ypre_next;
            slope_reg <= slope_next;
            xpre_reg  <= xpre_next;
            x_acc_reg <= x_acc_next;
            prod_reg  <= prod_next;
            sum_reg   <= sum_next;
            first_reg <= first_next;
            stop_reg  <= stop_next;
            flat_reg  <= flat_next;
        end
    end

endmodule

FILE: design/edge_scanline_stepper_unit.sv
// ----------------------------------------------------------------------------
// edge_scanline_stepper_unit
// Step request: result via the command and result queues, one per cycle sustained
// while the result queue has room. Load request: slope from the one-bit-per-cycle
// divider, then ten passes through the shared multiplier; flat edges skip the divide.
// Reset clears all gradients, accumulators, row bounds and both queues.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module edge_scanline_stepper_unit
    import esss_pkg::*;
#(
    parameter int FRAC_BITS   = 16,
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic                       cmd,
    input  logic signed [COORD_W-1:0]  start_x,
    input  logic signed [COORD_W-1:0]  start_y,
    input  logic signed [COORD_W-1:0]  end_x,
    input  logic signed [COORD_W-1:0]  end_y,
    input  logic signed [VAL_W-1:0]    start_u,
    input  logic signed [VAL_W-1:0]    start_v,
    input  logic signed [VAL_W-1:0]    start_w,
    output logic                       empty,
    input  logic                       pop,
    output logic signed [ROW_W-1:0]    row_first,
    output logic signed [ROW_W-1:0]    row_stop,
    output logic signed [VAL_W-1:0]    edge_x,
    output logic signed [VAL_W-1:0]    tex_u,
    output logic signed [VAL_W-1:0]    tex_v,
    output logic signed [VAL_W-1:0]    inv_depth,
    output logic                       degenerate,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_W-1:0]           cfg_data
);

    cq_entry_t front_entry;
    cq_entry_t cq_rdata;
    logic      cq_empty;
    logic      cq_pop;
    div_req_t  div_req;
    div_rsp_t  div_rsp;
    result_t   oq_wdata;
    result_t   oq_rdata;
    logic      oq_push;
    logic      oq_full;

    esss_front u_front (
        .cmd     (cmd),
        .start_x (start_x),
        .start_y (start_y),
        .end_x   (end_x),
        .end_y   (end_y),
        .start_u (start_u),
        .start_v (start_v),
        .start_w (start_w),
        .entry   (front_entry)
    );

    esss_fifo #(
        .WIDTH ($bits(cq_entry_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (front_entry),
        .full  (full),
        .pop   (cq_pop),
        .rdata (cq_rdata),
        .empty (cq_empty)
    );

    esss_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    esss_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cq_rdata  (cq_rdata),
        .cq_empty  (cq_empty),
        .cq_pop    (cq_pop),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .oq_wdata  (oq_wdata),
        .oq_push   (oq_push),
        .oq_full   (oq_full)
    );

    esss_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (oq_push),
        .wdata (oq_wdata),
        .full  (oq_full),
        .pop   (pop),
        .rdata (oq_rdata),
        .empty (empty)
    );

    assign row_first  = oq_rdata.row_first;
    assign row_stop   = oq_rdata.row_stop;
    assign edge_x     = oq_rdata.edge_x;
    assign tex_u      = oq_rdata.tex_u;
    assign tex_v      = oq_rdata.tex_v;
    assign inv_depth  = oq_rdata.inv_depth;
    assign degenerate = oq_rdata.degenerate;

endmodule
